### hdl/rc4_pkg.sv
// rc4_pkg: shared types and constants for the rc4 drop keystream cipher core
// depends on nothing; imported by rc4_ram users, rc4_engine and the top level
package rc4_pkg;

  localparam int BYTE_W         = 8;
  localparam int PERM_DEPTH     = 256;
  localparam int KEY_MAX_DEF    = 256;
  localparam int DROP_COUNT_DEF = 1024;

  typedef logic [BYTE_W-1:0] byte_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCHED_A,
    ST_SCHED_B,
    ST_SCHED_C,
    ST_SCHED_D,
    ST_GEN_A,
    ST_GEN_B,
    ST_GEN_C,
    ST_GEN_D,
    ST_GEN_E
  } state_t;

  // input item kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // permutation memory access from the sequencer
  typedef struct packed {
    logic  we;
    byte_t waddr;
    byte_t wdata;
    byte_t raddr;
  } perm_port_t;

  // finished result handed to the output register
  typedef struct packed {
    logic  valid;
    byte_t data;
  } result_t;

endpackage

### hdl/rc4_ram.sv
// rc4_ram: generic single-write, single-read ram with registered read data
// no dependencies; a read at the address being written returns the old data
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/rc4_engine.sv
// rc4_engine: sequencer and datapath for key load, key schedule, drop and keystream
// depends on rc4_pkg; drives the permutation ram and the key ram of the top level
module rc4_engine #(
  parameter int KEY_MAX    = rc4_pkg::KEY_MAX_DEF,
  parameter int DROP_COUNT = rc4_pkg::DROP_COUNT_DEF,
  parameter int KAW        = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     kind,
  input  logic [rc4_pkg::BYTE_W-1:0] value,
  input  logic                     last_key,
  input  logic                     out_busy,
  output rc4_pkg::result_t         res,
  output rc4_pkg::perm_port_t      perm,
  input  rc4_pkg::byte_t           perm_rdata,
  output logic                     key_we,
  output logic [KAW-1:0]           key_waddr,
  output rc4_pkg::byte_t           key_wdata,
  output logic [KAW-1:0]           key_raddr,
  input  rc4_pkg::byte_t           key_rdata
);

  import rc4_pkg::*;

  localparam int KCW = $clog2(KEY_MAX + 1);
  localparam int DW  = (DROP_COUNT > 0) ? $clog2(DROP_COUNT + 1) : 1;
  localparam logic [KCW-1:0] KEY_FULL  = KCW'(KEY_MAX);
  localparam logic [DW-1:0]  DROP_LAST = DW'((DROP_COUNT > 0) ? DROP_COUNT - 1 : 0);

  state_t          state, state_next;
  byte_t           cnt;        // fill and schedule step
  byte_t           idx_a;
  byte_t           idx_b;      // also the schedule accumulator
  byte_t           ta, tb;
  byte_t           data;
  logic [KAW-1:0]  kidx;
  logic [KCW-1:0]  key_count;
  logic [DW-1:0]   dcnt;
  logic            keyed;
  logic            mode_data;

  logic            accept;
  byte_t           a_inc, b_sum, acc_new, ks_addr, ks_byte;
  logic            kidx_wrap;

  assign accept    = in_valid && !in_stall;
  assign a_inc     = idx_a + 8'd1;
  assign b_sum     = idx_b + perm_rdata;
  assign acc_new   = idx_b + perm_rdata + key_rdata;
  assign ks_addr   = ta + tb;
  // the read of ks_addr was issued while S[b] was written: forward ta
  assign ks_byte   = (ks_addr == idx_b) ? ta : perm_rdata;
  assign kidx_wrap = (KCW'(kidx) + KCW'(1)) == key_count;

  // key ram writes come straight from accepted key items
  assign key_we    = accept && (kind == KIND_KEY) && (key_count < KEY_FULL);
  assign key_waddr = key_count[KAW-1:0];
  assign key_wdata = value;
  assign key_raddr = kidx;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    perm       = '0;
    res        = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          if (kind == KIND_KEY) begin
            if (last_key) begin
              state_next = ST_FILL;
            end
          end else if (keyed) begin
            state_next = ST_GEN_A;
          end
        end
      end
      ST_FILL: begin
        perm.we    = 1'b1;
        perm.waddr = cnt;
        perm.wdata = cnt;
        if (cnt == 8'hFF) begin
          state_next = ST_SCHED_A;
        end
      end
      ST_SCHED_A: begin
        perm.raddr = cnt;
        state_next = ST_SCHED_B;
      end
      ST_SCHED_B: begin
        perm.raddr = acc_new;
        state_next = ST_SCHED_C;
      end
      ST_SCHED_C: begin
        perm.we    = 1'b1;
        perm.waddr = cnt;
        perm.wdata = perm_rdata;
        state_next = ST_SCHED_D;
      end
      ST_SCHED_D: begin
        perm.we    = 1'b1;
        perm.waddr = idx_b;
        perm.wdata = ta;
        if (cnt != 8'hFF) begin
          state_next = ST_SCHED_A;
        end else if (DROP_COUNT > 0) begin
          state_next = ST_GEN_A;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_GEN_A: begin
        perm.raddr = a_inc;
        state_next = ST_GEN_B;
      end
      ST_GEN_B: begin
        perm.raddr = b_sum;
        state_next = ST_GEN_C;
      end
      ST_GEN_C: begin
        perm.we    = 1'b1;
        perm.waddr = idx_a;
        perm.wdata = perm_rdata;
        state_next = ST_GEN_D;
      end
      ST_GEN_D: begin
        perm.we    = 1'b1;
        perm.waddr = idx_b;
        perm.wdata = ta;
        perm.raddr = ks_addr;
        if (mode_data) begin
          state_next = ST_GEN_E;
        end else if (dcnt == DROP_LAST) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_GEN_A;
        end
      end
      ST_GEN_E: begin
        perm.raddr = ks_addr;
        if (!out_busy) begin
          res.valid  = 1'b1;
          res.data   = data ^ ks_byte;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      keyed     <= 1'b0;
      mode_data <= 1'b0;
      idx_a     <= '0;
      idx_b     <= '0;
      cnt       <= '0;
      kidx      <= '0;
      dcnt      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (kind == KIND_KEY) begin
              keyed <= 1'b0;
              if (key_count < KEY_FULL) begin
                key_count <= key_count + KCW'(1);
              end
              if (last_key) begin
                cnt       <= '0;
                kidx      <= '0;
                idx_b     <= '0;
                mode_data <= 1'b0;
              end
            end else begin
              mode_data <= 1'b1;
            end
          end
        end
        ST_FILL: begin
          cnt <= cnt + 8'd1;
        end
        ST_SCHED_B: begin
          idx_b <= acc_new;
        end
        ST_SCHED_D: begin
          cnt  <= cnt + 8'd1;
          kidx <= kidx_wrap ? '0 : kidx + KAW'(1);
          if (cnt == 8'hFF) begin
            idx_a <= 8'hFF;
            dcnt  <= '0;
            if (DROP_COUNT == 0) begin
              keyed     <= 1'b1;
              key_count <= '0;
            end
          end
        end
        ST_GEN_A: begin
          idx_a <= a_inc;
        end
        ST_GEN_B: begin
          idx_b <= b_sum;
        end
        ST_GEN_D: begin
          if (!mode_data) begin
            dcnt <= dcnt + DW'(1);
            if (dcnt == DROP_LAST) begin
              keyed     <= 1'b1;
              key_count <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      data <= value;
    end
    if (state == ST_SCHED_B || state == ST_GEN_B) begin
      ta <= perm_rdata;
    end
    if (state == ST_GEN_C) begin
      tb <= perm_rdata;
    end
  end

endmodule

### hdl/rc4_drop_keystream_cipher_core.sv
// rc4_drop_keystream_cipher_core: top level with the two rams and the output register
// depends on rc4_pkg, rc4_ram and rc4_engine
//
// usage
//   input channel (in_valid, in_stall, kind, value, last_key): kind 0 is a key
//   byte, kind 1 a data byte. key bytes are stored in order; the one with
//   last_key set starts the key schedule and the keystream drop. a data byte
//   gives one item on the output channel (out_valid, out_stall, out_byte)
//   holding value xor the next keystream byte, but only once a key is set up;
//   before that it is taken and dropped. key bytes past KEY_MAX are not stored,
//   and any key byte invalidates the current key.
//   sequencing: the permutation lives in one ram with one read and one write
//   port and registered read, so each keystream byte costs a read-swap-read
//   sequence. a data item walks ST_GEN_A to ST_GEN_E before its result is
//   registered, and the next item is taken only after that. a non-final key
//   byte leaves the core idle; the final one adds the table fill, the schedule
//   (ST_SCHED_A to ST_SCHED_D per step) and the drop, with in_stall high.
//   a finished result waits in the output register while out_stall is high;
//   key bytes are still taken then, a later data item waits for the register.
//   reset clears the key, the counters and the output register.
module rc4_drop_keystream_cipher_core #(
  parameter int KEY_MAX    = rc4_pkg::KEY_MAX_DEF,
  parameter int DROP_COUNT = rc4_pkg::DROP_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       kind,
  input  logic [rc4_pkg::BYTE_W-1:0] value,
  input  logic                       last_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rc4_pkg::BYTE_W-1:0] out_byte
);

  import rc4_pkg::*;

  localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  perm_port_t     perm;
  byte_t          perm_rdata;
  logic           key_we;
  logic [KAW-1:0] key_waddr, key_raddr;
  byte_t          key_wdata, key_rdata;
  result_t        res;
  logic           out_busy;

  assign out_busy = out_valid && out_stall;

  rc4_engine #(
    .KEY_MAX    (KEY_MAX),
    .DROP_COUNT (DROP_COUNT),
    .KAW        (KAW)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .value      (value),
    .last_key   (last_key),
    .out_busy   (out_busy),
    .res        (res),
    .perm       (perm),
    .perm_rdata (perm_rdata),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .key_raddr  (key_raddr),
    .key_rdata  (key_rdata)
  );

  // permutation table
  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PERM_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (perm.we),
    .waddr (perm.waddr),
    .wdata (perm.wdata),
    .raddr (perm.raddr),
    .rdata (perm_rdata)
  );

  // key store
  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_MAX),
    .AW    (KAW)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_byte <= res.data;
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for rc4_drop_keystream_cipher_core (key load, drop, xor)
// depends on rc4_pkg and the core; an rc4 model inside the bench predicts every out_byte
module tb_top;
  import rc4_pkg::*;

  localparam int          RAND_ITEMS = 1100;
  localparam int          LONG_HOLD  = 300;
  localparam int unsigned LIMIT_NS   = 10_000_000;

  // what a directed row promises
  typedef enum logic {WANT_NONE, WANT_CALC} want_t;

  typedef struct packed {
    logic  k;
    byte_t v;
    logic  l;
    want_t w;
  } dir_row_t;

  localparam int DIR_ROWS = 19;

  // directed rows: no result is due before a key is complete
  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{KIND_DATA, 8'h00, 1'b0, WANT_NONE},  // data before any key
    '{KIND_DATA, 8'hFF, 1'b1, WANT_NONE},  // flag on data must not start setup
    '{KIND_KEY,  8'h00, 1'b0, WANT_NONE},
    '{KIND_DATA, 8'h5A, 1'b0, WANT_NONE},  // data while key is loading
    '{KIND_KEY,  8'hFF, 1'b1, WANT_NONE},  // two byte key
    '{KIND_DATA, 8'h00, 1'b0, WANT_CALC},
    '{KIND_DATA, 8'hFF, 1'b0, WANT_CALC},
    '{KIND_DATA, 8'hA5, 1'b1, WANT_CALC},  // flag on data ignored
    '{KIND_DATA, 8'h3C, 1'b0, WANT_CALC},
    '{KIND_KEY,  8'h80, 1'b1, WANT_NONE},  // one byte key replaces a live key
    '{KIND_DATA, 8'h01, 1'b0, WANT_CALC},
    '{KIND_DATA, 8'hFE, 1'b0, WANT_CALC},
    '{KIND_KEY,  8'h01, 1'b0, WANT_NONE},  // any key byte drops the key
    '{KIND_DATA, 8'h77, 1'b0, WANT_NONE},
    '{KIND_KEY,  8'h7F, 1'b0, WANT_NONE},
    '{KIND_KEY,  8'hFE, 1'b1, WANT_NONE},
    '{KIND_DATA, 8'h00, 1'b0, WANT_CALC},
    '{KIND_DATA, 8'h80, 1'b0, WANT_CALC},
    '{KIND_DATA, 8'hFF, 1'b0, WANT_CALC}
  };

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  logic  kind;
  byte_t value;
  logic  last_key;
  logic  out_valid;
  logic  out_stall;
  byte_t out_byte;

  // bench control
  bit quiet;
  bit gaps_on;
  bit long_hold_req;
  int err_cnt;

  // cipher state mirror
  byte_t       perm_s [0:PERM_DEPTH-1];
  byte_t       key_s  [0:KEY_MAX_DEF-1];
  int unsigned key_len;
  byte_t       idx_i;
  byte_t       idx_j;
  bit          key_ready;

  // out_byte values still owed by the core, oldest first
  byte_t crypt_q [$];

  rc4_drop_keystream_cipher_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .value     (value),
    .last_key  (last_key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (err_cnt < 40) $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // one keystream byte: step indices, swap, look up
  function automatic byte_t next_ks();
    byte_t t_a;
    byte_t t_b;
    byte_t sum;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm_s[idx_i];
    t_a = perm_s[idx_i];
    t_b = perm_s[idx_j];
    perm_s[idx_i] = t_b;
    perm_s[idx_j] = t_a;
    sum = perm_s[idx_i] + perm_s[idx_j];
    return perm_s[sum];
  endfunction

  // key schedule over the stored key, then the keystream drop
  function automatic void run_key_schedule();
    byte_t acc;
    byte_t t_a;
    for (int n = 0; n < PERM_DEPTH; n++) perm_s[n] = byte_t'(n);
    acc = 8'd0;
    for (int n = 0; n < PERM_DEPTH; n++) begin
      acc = acc + perm_s[n] + key_s[n % key_len];
      t_a = perm_s[n];
      perm_s[n] = perm_s[acc];
      perm_s[acc] = t_a;
    end
    idx_j = acc;
    idx_i = 8'hFF;
    for (int n = 0; n < DROP_COUNT_DEF; n++) void'(next_ks());
    key_len = 0;
    key_ready = 1'b1;
  endfunction

  // one accepted item; returns 1 with the crypted byte when a result is due
  function automatic bit crypt_step(input logic k, input byte_t v, input logic l,
                                    output byte_t res);
    res = 8'd0;
    if (k == KIND_KEY) begin
      key_ready = 1'b0;
      if (key_len < KEY_MAX_DEF) begin
        key_s[key_len] = v;
        key_len++;
      end
      if (l) run_key_schedule();
      return 1'b0;
    end
    if (!key_ready) return 1'b0;
    res = v ^ next_ks();
    return 1'b1;
  endfunction

  // offer one item from a falling edge until it is taken
  task automatic send_byte(input logic k, input byte_t v, input logic l, output bit got);
    byte_t res;
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    last_key <= l;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = crypt_step(k, v, l, res);
    if (got) crypt_q.push_back(res);
    @(negedge clk);
  endtask

  // output check against the oldest owed byte
  always @(posedge clk) begin
    byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (crypt_q.size() == 0) begin
        report_mismatch($sformatf("out_byte %02h with nothing pending", out_byte));
      end else begin
        want = crypt_q.pop_front();
        if (out_byte !== want)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want));
      end
    end
  end

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin : rx_side
    int  seg_left;
    bit  seg_stall;
    seg_left  = 0;
    seg_stall = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        seg_left = 0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_stall = ($urandom_range(0, 2) == 0);
          seg_left  = seg_stall ? $urandom_range(1, 14) : $urandom_range(1, 40);
        end
        out_stall <= seg_stall;
        seg_left--;
      end
    end
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("** rc4_drop_keystream_cipher_core: FAILED **");
    $finish;
  end

  // stimulus
  initial begin
    int  sent;
    int  len;
    int  pick;
    int  keys_done;
    bit  got;
    bit  hold_done;
    bit  long_key_done;

    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = KIND_KEY;
    value         = 8'd0;
    last_key      = 1'b0;
    quiet         = 1'b0;
    gaps_on       = 1'b1;
    long_hold_req = 1'b0;
    err_cnt       = 0;
    key_len       = 0;
    idx_i         = 8'd0;
    idx_j         = 8'd0;
    key_ready     = 1'b0;
    sent          = 0;
    keys_done     = 0;
    hold_done     = 1'b0;
    long_key_done = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    for (int n = 0; n < DIR_ROWS; n++) begin
      send_byte(dir_tab[n].k, dir_tab[n].v, dir_tab[n].l, got);
      if (dir_tab[n].w == WANT_NONE && got)
        report_mismatch($sformatf("directed row %0d gave a result where none is due", n));
      if (dir_tab[n].w == WANT_CALC && !got)
        report_mismatch($sformatf("directed row %0d gave no result", n));
    end

    // random segments: keys of random length, then data runs
    while (sent < RAND_ITEMS) begin
      pick    = $urandom_range(0, 99);
      gaps_on = ($urandom_range(0, 9) < 7);
      if (!long_key_done && sent > 300) begin
        // overlong key: store fills up, the rest is dropped, flag still starts setup
        len = $urandom_range(KEY_MAX_DEF + 1, KEY_MAX_DEF + 4);
        for (int n = 0; n < len; n++)
          send_byte(KIND_KEY, byte_t'($urandom_range(0, 255)), n == len - 1, got);
        sent += len;
        keys_done++;
        long_key_done = 1'b1;
      end else if (pick < 10 && keys_done < 16) begin
        len = (pick < 3) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        for (int n = 0; n < len; n++)
          send_byte(KIND_KEY, byte_t'($urandom_range(0, 255)), n == len - 1, got);
        sent += len;
        keys_done++;
      end else if (pick < 14 && keys_done < 16) begin
        // broken key load: data mixed in, nothing comes out until the flag
        len = $urandom_range(1, 6);
        for (int n = 0; n < len; n++) begin
          send_byte(KIND_KEY, byte_t'($urandom_range(0, 255)), 1'b0, got);
          send_byte(KIND_DATA, byte_t'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), got);
        end
        send_byte(KIND_KEY, byte_t'($urandom_range(0, 255)), 1'b1, got);
        sent += 2 * len + 1;
        keys_done++;
      end

      len = hold_done ? $urandom_range(1, 30) : 40;
      for (int n = 0; n < len; n++) begin
        send_byte(KIND_DATA, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), got);
        // fill the core behind a long output hold-off
        if (!hold_done) begin
          long_hold_req = 1'b1;
          hold_done     = 1'b1;
        end
      end
      sent += len;
      if (sent > RAND_ITEMS - 100) quiet = 1'b1;
    end
    in_valid <= 1'b0;

    // drain, then watch for anything stray
    for (int n = 0; n < 5000 && crypt_q.size() != 0; n++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (crypt_q.size() != 0)
      report_mismatch($sformatf("%0d out_byte items never arrived", crypt_q.size()));

    if (err_cnt == 0) begin
      $display("** rc4_drop_keystream_cipher_core: PASSED **");
    end else begin
      $display("** rc4_drop_keystream_cipher_core: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/rc4_pkg.sv
hdl/rc4_ram.sv
hdl/rc4_engine.sv
hdl/rc4_drop_keystream_cipher_core.sv
tb/tb_top.sv
